@@ rtl/asd_pkg.sv @@
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types and constants of the accelerometer shake detector.
// ----------------------------------------------------------------------------
package asd_pkg;

  localparam int unsigned AXIS_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned CFG_W  = 32;

  // register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_DEBOUNCE  = 1'b1;

  // axis select codes for the shared squarer
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CHECK  = 9'b000000010,
    ST_MX     = 9'b000000100,
    ST_MY     = 9'b000001000,
    ST_MZ     = 9'b000010000,
    ST_MSUM   = 9'b000100000,
    ST_RINIT  = 9'b001000000,
    ST_ROOT   = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_e;

  typedef struct packed {
    logic       load;
    logic       check;
    logic       mul_en;
    logic [1:0] axis;
    logic       sum_load;
    logic       sum_add;
    logic       root_init;
    logic       root_step;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic in_window;
    logic root_last;
  } status_t;

endpackage

@@ rtl/asd_datapath.sv @@
// ----------------------------------------------------------------------------
// asd_datapath
// Sample registers, shared squarer, iterative square root and shake state.
// ----------------------------------------------------------------------------
module asd_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_index_i,
  input  logic [asd_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic signed [asd_pkg::AXIS_W-1:0] accel_x_sample_i,
  input  logic signed [asd_pkg::AXIS_W-1:0] accel_y_sample_i,
  input  logic signed [asd_pkg::AXIS_W-1:0] accel_z_sample_i,
  input  logic [asd_pkg::TIME_W-1:0]       time_ms_i,
  input  asd_pkg::cmd_t                    cmd_i,
  output asd_pkg::status_t                 status_o,
  output logic                             shaken_o
);

  logic [asd_pkg::AXIS_W-1:0] thr_q;
  logic [asd_pkg::TIME_W-1:0] intv_q;
  logic [asd_pkg::MAG_W-1:0]  prev_mag_q;
  logic [asd_pkg::TIME_W-1:0] last_ms_q;

  logic signed [asd_pkg::AXIS_W-1:0] x_q, y_q, z_q;
  logic [asd_pkg::TIME_W-1:0] time_q;
  logic win_q;

  logic [asd_pkg::AXIS_W-1:0] axis_abs;
  logic signed [asd_pkg::AXIS_W-1:0] axis_val;
  logic [asd_pkg::SUM_W-1:0] prod_q, sum_q;
  logic [asd_pkg::SUM_W-1:0] rem_q, root_q, bit_q, trial;
  logic [asd_pkg::MAG_W-1:0] mag, change;
  logic [asd_pkg::TIME_W-1:0] elapsed;
  logic shaken_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      intv_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        asd_pkg::REG_THRESHOLD: thr_q  <= cfg_wdata_i[asd_pkg::AXIS_W-1:0];
        asd_pkg::REG_DEBOUNCE:  intv_q <= cfg_wdata_i[asd_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= accel_x_sample_i;
      y_q    <= accel_y_sample_i;
      z_q    <= accel_z_sample_i;
      time_q <= time_ms_i;
    end
  end

  assign elapsed = time_q - last_ms_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      win_q <= (elapsed < intv_q);
    end
  end

  always_comb begin
    case (cmd_i.axis)
      asd_pkg::AXIS_X: axis_val = x_q;
      asd_pkg::AXIS_Y: axis_val = y_q;
      default:         axis_val = z_q;
    endcase
    axis_abs = axis_val[asd_pkg::AXIS_W-1] ? (~axis_val + 1'b1) : axis_val;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= axis_abs * axis_abs;
    end
    if (cmd_i.sum_load) begin
      sum_q <= prod_q;
    end else if (cmd_i.sum_add) begin
      sum_q <= sum_q + prod_q;
    end
  end

  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      rem_q  <= sum_q;
      root_q <= '0;
      bit_q  <= {2'b01, {(asd_pkg::SUM_W-2){1'b0}}};
    end else if (cmd_i.root_step) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign mag    = root_q[asd_pkg::MAG_W-1:0];
  assign change = (mag >= prev_mag_q) ? (mag - prev_mag_q) : (prev_mag_q - mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mag_q <= '0;
      last_ms_q  <= '0;
    end else if (cmd_i.finish && !win_q) begin
      prev_mag_q <= mag;
      if (change > thr_q) begin
        last_ms_q <= time_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      shaken_q <= !win_q && (change > thr_q);
    end
  end

  assign status_o.in_window = win_q;
  assign status_o.root_last = bit_q[0];
  assign shaken_o           = shaken_q;

endmodule

@@ rtl/asd_ctrl.sv @@
// ----------------------------------------------------------------------------
// asd_ctrl
// Per sample: window check, squares and root if outside, commit, output word.
// ----------------------------------------------------------------------------
module asd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  asd_pkg::status_t status_i,
  output asd_pkg::cmd_t    cmd_o
);

  asd_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic fin_go;

  assign fin_go = (state_q == asd_pkg::ST_FINISH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.axis = asd_pkg::AXIS_X;
    unique case (state_q)
      asd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = asd_pkg::ST_CHECK;
        end
      end
      asd_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = asd_pkg::ST_MX;
      end
      asd_pkg::ST_MX: begin
        if (status_i.in_window) begin
          state_d = asd_pkg::ST_FINISH;
        end else begin
          cmd_o.mul_en = 1'b1;
          cmd_o.axis   = asd_pkg::AXIS_X;
          state_d      = asd_pkg::ST_MY;
        end
      end
      asd_pkg::ST_MY: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.axis     = asd_pkg::AXIS_Y;
        cmd_o.sum_load = 1'b1;
        state_d        = asd_pkg::ST_MZ;
      end
      asd_pkg::ST_MZ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.axis    = asd_pkg::AXIS_Z;
        cmd_o.sum_add = 1'b1;
        state_d       = asd_pkg::ST_MSUM;
      end
      asd_pkg::ST_MSUM: begin
        cmd_o.sum_add = 1'b1;
        state_d       = asd_pkg::ST_RINIT;
      end
      asd_pkg::ST_RINIT: begin
        cmd_o.root_init = 1'b1;
        state_d         = asd_pkg::ST_ROOT;
      end
      asd_pkg::ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (status_i.root_last) begin
          state_d = asd_pkg::ST_FINISH;
        end
      end
      asd_pkg::ST_FINISH: begin
        if (fin_go) begin
          cmd_o.finish = 1'b1;
          state_d      = asd_pkg::ST_IDLE;
        end
      end
      default: state_d = asd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != asd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("controller state not one-hot");

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> (state_q == asd_pkg::ST_IDLE) && out_valid_q)
    else $error("finish did not present a result word");

  a_root_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asd_pkg::ST_ROOT) && status_i.root_last |=> (state_q == asd_pkg::ST_FINISH))
    else $error("root iteration did not end in finish");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == asd_pkg::ST_FINISH)
    else $error("result word raised outside finish");

endmodule

@@ rtl/accel_shake_detector_core.sv @@
// ----------------------------------------------------------------------------
// accel_shake_detector_core
// Shake detection on accelerometer samples with a debounce window.
// ----------------------------------------------------------------------------
// An input word is one sample (three signed axes and a millisecond time),
// taken when in_valid_i is high and in_stall_o is low. Each sample gives one
// result word, shaken_o, offered on out_valid_o and taken when out_stall_i is
// low. Registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i:
// index 0 is the shake threshold, index 1 the debounce interval.
// A sample inside the debounce window goes from the window check straight to
// the commit; any other sample first passes the shared squarer (one axis per
// cycle) and the 16-step bit-by-bit square root. One sample is processed at
// a time; the next is accepted once the previous one has been committed.
// The result sits in an output register, so a new sample can be taken while
// it waits; if the receiver still stalls when the next result is ready, the
// block holds in its final step until the word is taken.
// Reset clears the registers, the previous magnitude and the last shake time.
// ----------------------------------------------------------------------------
module accel_shake_detector_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [asd_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [asd_pkg::AXIS_W-1:0] accel_x_sample_i,
  input  logic signed [asd_pkg::AXIS_W-1:0] accel_y_sample_i,
  input  logic signed [asd_pkg::AXIS_W-1:0] accel_z_sample_i,
  input  logic [asd_pkg::TIME_W-1:0]        time_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              shaken_o
);

  asd_pkg::cmd_t    cmd;
  asd_pkg::status_t status;

  asd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  asd_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .accel_x_sample_i (accel_x_sample_i),
    .accel_y_sample_i (accel_y_sample_i),
    .accel_z_sample_i (accel_z_sample_i),
    .time_ms_i        (time_ms_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .shaken_o         (shaken_o)
  );

endmodule

@@ verif/accel_shake_detector_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_shake_detector_checker
// Watches the register port and both word channels of the shake detector.
// Keeps its own copy of the registers, the previous magnitude and the last
// shake time, predicts the shaken flag of every accepted sample and compares
// each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module accel_shake_detector_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [asd_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic signed [asd_pkg::AXIS_W-1:0] accel_x_sample_i,
  input  logic signed [asd_pkg::AXIS_W-1:0] accel_y_sample_i,
  input  logic signed [asd_pkg::AXIS_W-1:0] accel_z_sample_i,
  input  logic [asd_pkg::TIME_W-1:0]        time_ms_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic                              shaken_i,
  output int unsigned                       error_count_o,
  output int unsigned                       outstanding_o
);

  logic [asd_pkg::MAG_W-1:0]  threshold;
  logic [asd_pkg::TIME_W-1:0] debounce;
  logic [asd_pkg::MAG_W-1:0]  prev_mag;
  logic [asd_pkg::TIME_W-1:0] last_shake;
  logic                       shaken_due[$];
  logic                       shaken_exp;
  int unsigned                mismatches = 0;

  assign error_count_o = mismatches;

  function automatic logic [asd_pkg::SUM_W-1:0] axis_square(
      input logic signed [asd_pkg::AXIS_W-1:0] v);
    int s;
    int p;
    s = v;
    if (s < 0) begin
      s = -s;
    end
    p = s * s;
    return p[asd_pkg::SUM_W-1:0];
  endfunction

  // bit-by-bit floor square root
  function automatic logic [asd_pkg::MAG_W-1:0] floor_root(
      input logic [asd_pkg::SUM_W-1:0] n);
    logic [asd_pkg::SUM_W-1:0] root;
    logic [asd_pkg::SUM_W-1:0] rest;
    logic [asd_pkg::SUM_W-1:0] one;
    root = '0;
    rest = n;
    one  = 32'h4000_0000;
    while (one != 0) begin
      if (rest >= root + one) begin
        rest = rest - (root + one);
        root = (root >> 1) + one;
      end else begin
        root = root >> 1;
      end
      one = one >> 2;
    end
    return root[asd_pkg::MAG_W-1:0];
  endfunction

  function automatic logic predict_shake(input logic signed [asd_pkg::AXIS_W-1:0] x,
                                         input logic signed [asd_pkg::AXIS_W-1:0] y,
                                         input logic signed [asd_pkg::AXIS_W-1:0] z,
                                         input logic [asd_pkg::TIME_W-1:0] now);
    logic [asd_pkg::SUM_W-1:0]  sum;
    logic [asd_pkg::MAG_W-1:0]  mag;
    logic [asd_pkg::MAG_W-1:0]  change;
    logic [asd_pkg::TIME_W-1:0] elapsed;
    elapsed = now - last_shake;
    if (elapsed < debounce) begin
      return 1'b0;
    end
    sum    = axis_square(x) + axis_square(y) + axis_square(z);
    mag    = floor_root(sum);
    change = (mag >= prev_mag) ? mag - prev_mag : prev_mag - mag;
    prev_mag = mag;
    if (change > threshold) begin
      last_shake = now;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold  = '0;
      debounce   = '0;
      prev_mag   = '0;
      last_shake = '0;
      shaken_due.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (shaken_due.size() == 0) begin
          $error("unexpected result word, shaken actual %0b", shaken_i);
          mismatches++;
        end else begin
          shaken_exp = shaken_due.pop_front();
          if (shaken_i !== shaken_exp) begin
            $error("shaken: expected %0b, actual %0b", shaken_exp, shaken_i);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          asd_pkg::REG_THRESHOLD: threshold = cfg_wdata_i[asd_pkg::MAG_W-1:0];
          asd_pkg::REG_DEBOUNCE:  debounce  = cfg_wdata_i[asd_pkg::TIME_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        shaken_due.push_back(predict_shake(accel_x_sample_i, accel_y_sample_i,
                                           accel_z_sample_i, time_ms_i));
      end
      outstanding_o <= shaken_due.size();
    end
  end

endmodule

@@ verif/accel_shake_detector_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_shake_detector_core_test
// Drives samples and register writes into the shake detector core and gives
// the verdict. A directed opening covers the debounce window edges, the
// threshold edge, timestamp wrap and the axis extremes; random phases then
// sweep thresholds and debounce intervals with drifting and jolting samples,
// random idling on both channels, a calm stretch and one long output hold-off.
// ----------------------------------------------------------------------------
module accel_shake_detector_core_test;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned PHASE_WORDS   = 110;
  localparam int unsigned NUM_PHASES    = 8;

  localparam logic signed [asd_pkg::AXIS_W-1:0] AX_ZERO = 16'sh0000;
  localparam logic signed [asd_pkg::AXIS_W-1:0] AX_MIN  = 16'sh8000;
  localparam logic signed [asd_pkg::AXIS_W-1:0] AX_MAX  = 16'sh7FFF;
  localparam logic signed [asd_pkg::AXIS_W-1:0] AX_NEG1 = 16'shFFFF;

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic                              cfg_index = asd_pkg::REG_THRESHOLD;
  logic [asd_pkg::CFG_W-1:0]         cfg_wdata = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [asd_pkg::AXIS_W-1:0] accel_x = '0;
  logic signed [asd_pkg::AXIS_W-1:0] accel_y = '0;
  logic signed [asd_pkg::AXIS_W-1:0] accel_z = '0;
  logic [asd_pkg::TIME_W-1:0]        time_ms = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              shaken;

  int unsigned                error_count;
  int unsigned                outstanding;
  int unsigned                cycle_count = 0;
  bit                         calm = 1'b0;
  bit                         hold_req = 1'b0;
  int unsigned                hold_left = 0;
  logic [asd_pkg::TIME_W-1:0] clock_ms = '0;
  int unsigned                step_max = 100;

  accel_shake_detector_core uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .accel_x_sample_i (accel_x),
    .accel_y_sample_i (accel_y),
    .accel_z_sample_i (accel_z),
    .time_ms_i        (time_ms),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .shaken_o         (shaken)
  );

  accel_shake_detector_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .accel_x_sample_i (accel_x),
    .accel_y_sample_i (accel_y),
    .accel_z_sample_i (accel_z),
    .time_ms_i        (time_ms),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .shaken_i         (shaken),
    .error_count_o    (error_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("accel_shake_detector_core_test: errors");
    $finish;
  end

  // result side: random stall, a calm stretch and one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 26);
      end
    end
  end

  task automatic send_sample(input logic signed [asd_pkg::AXIS_W-1:0] x,
                             input logic signed [asd_pkg::AXIS_W-1:0] y,
                             input logic signed [asd_pkg::AXIS_W-1:0] z,
                             input logic [asd_pkg::TIME_W-1:0] now);
    in_valid <= 1'b1;
    accel_x  <= x;
    accel_y  <= y;
    accel_z  <= z;
    time_ms  <= now;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [asd_pkg::CFG_W-1:0] thr_word,
                            input logic [asd_pkg::CFG_W-1:0] deb_word);
    cfg_we    <= 1'b1;
    cfg_index <= asd_pkg::REG_THRESHOLD;
    cfg_wdata <= thr_word;
    @(posedge clk);
    cfg_index <= asd_pkg::REG_DEBOUNCE;
    cfg_wdata <= deb_word;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drift around a resting value, full random, jolts and extremes
  function automatic logic signed [asd_pkg::AXIS_W-1:0] axis_value(input int rest);
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 40) begin
      v = rest + int'($urandom_range(0, 400)) - 200;
    end else if (pick < 70) begin
      v = $urandom;
    end else if (pick < 90) begin
      v = int'($urandom_range(0, 16000)) - 8000;
    end else begin
      case ($urandom_range(3))
        0:       v = -32768;
        1:       v = 32767;
        2:       v = 0;
        default: v = -1;
      endcase
    end
    return v[asd_pkg::AXIS_W-1:0];
  endfunction

  function automatic logic [asd_pkg::TIME_W-1:0] next_time();
    if ($urandom_range(99) < 5) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, step_max);
    end
    return clock_ms;
  endfunction

  initial begin
    logic [asd_pkg::CFG_W-1:0] thr_word;
    logic [asd_pkg::CFG_W-1:0] deb_word;
    int                        rest_x;
    int                        rest_y;
    int                        rest_z;
    int unsigned               words;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_regs(32'd100, 32'd50);
    // early samples fall in the window since last shake time starts at zero
    send_sample(AX_ZERO, AX_ZERO, AX_ZERO, 32'd10);
    send_sample(AX_MIN, AX_MIN, AX_MIN, 32'd49);
    send_sample(AX_MIN, AX_MIN, AX_MIN, 32'd50);
    send_sample(AX_MAX, AX_MAX, AX_MAX, 32'd99);
    send_sample(AX_MAX, AX_MAX, AX_MAX, 32'd100);
    send_sample(AX_ZERO, AX_ZERO, AX_ZERO, 32'd150);
    // change equal to threshold, then one above
    send_sample(16'sd100, AX_ZERO, AX_ZERO, 32'd200);
    send_sample(AX_ZERO, AX_ZERO, AX_ZERO, 32'd201);
    send_sample(AX_ZERO, 16'sd101, AX_ZERO, 32'd202);
    send_sample(AX_NEG1, AX_NEG1, AX_NEG1, 32'd300);
    // shake just before the time wraps, window measured across the wrap
    send_sample(16'sd12345, -16'sd23456, 16'sd7, 32'hFFFF_FFF0);
    send_sample(AX_ZERO, AX_ZERO, AX_ZERO, 32'h0000_0010);
    send_sample(AX_ZERO, AX_ZERO, AX_ZERO, 32'h0000_0022);
    drain_results();

    // no window, zero threshold
    write_regs(32'd0, 32'd0);
    send_sample(AX_ZERO, AX_ZERO, AX_ZERO, 32'd0);
    send_sample(AX_ZERO, AX_ZERO, 16'sd1, 32'd0);
    send_sample(AX_ZERO, AX_ZERO, 16'sd1, 32'd0);
    drain_results();

    // largest settings, upper threshold bits ignored
    write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(AX_MIN, AX_MIN, AX_MIN, 32'd5);
    send_sample(AX_MIN, AX_MIN, AX_MIN, 32'hFFFF_FFFF);
    send_sample(AX_ZERO, AX_ZERO, AX_ZERO, 32'hFFFF_FFFF);
    drain_results();

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      thr_word = {16'($urandom), 16'($urandom_range(0, 1500))};
      deb_word = $urandom_range(0, 200);
      words    = PHASE_WORDS;
      calm     = (p == 1);
      case (p)
        3: begin
          thr_word = '0;
          deb_word = '0;
        end
        4: begin
          thr_word = 32'h0000_FFFF;
          deb_word = '0;
        end
        5: begin
          deb_word = $urandom;
          clock_ms = 32'hFFFF_F000;
        end
        6: begin
          deb_word = 32'hFFFF_FFFF;
          words    = 30;
        end
        7: begin
          thr_word = $urandom;
          deb_word = $urandom_range(0, 5000);
        end
        default: ;
      endcase
      step_max = (deb_word < 1000) ? 2 * deb_word + 10 : 1000;
      write_regs(thr_word, deb_word);
      rest_x = int'($urandom_range(0, 4000)) - 2000;
      rest_y = int'($urandom_range(0, 4000)) - 2000;
      rest_z = int'($urandom_range(0, 4000)) - 2000;
      for (int unsigned i = 0; i < words; i++) begin
        if (p == 2 && i == 5) begin
          hold_req = 1'b1;
        end
        send_sample(axis_value(rest_x), axis_value(rest_y), axis_value(rest_z),
                    next_time());
      end
      drain_results();
    end
    calm = 1'b0;

    if (error_count == 0 && outstanding == 0) begin
      $display("accel_shake_detector_core_test: clean");
    end else begin
      $display("accel_shake_detector_core_test: errors");
    end
    $finish;
  end

endmodule
